/* rtl/ecdss_pkg.sv */
// ----------------------------------------------------------------------------
// ecdss_pkg
// Shared types, widths and the sine table of the rotation counter core.
// ----------------------------------------------------------------------------
package ecdss_pkg;

    // Field widths.
    localparam int COUNT_W = 10;
    localparam int CMD_W   = 2;
    localparam int ANODE_W = 3;
    localparam int CATH_W  = 4;
    localparam int DAC_W   = 5;
    localparam int SCAN_W  = 2;

    // Count range and decimal scan.
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(999);
    localparam int DIGIT_BASE  = 10;
    localparam int LAST_DIGIT  = 2;

    // Reciprocal constants: exact quotients for every count up to the limit.
    localparam int DIV10_MUL    = 205;
    localparam int DIV10_SHIFT  = 11;
    localparam int DIV100_MUL   = 41;
    localparam int DIV100_SHIFT = 12;
    localparam int PROD_W       = COUNT_W + 8;

    // Sine table.
    localparam int  TABLE_SIZE     = 256;
    localparam int  SINE_AMPLITUDE = 15;
    localparam real SINE_TURN      = 6.283;
    localparam real SINE_STEP      = SINE_TURN / real'(TABLE_SIZE);
    localparam int  PHASE_W        = $clog2(TABLE_SIZE);
    localparam int  ROM_W          = $clog2(2 * SINE_AMPLITUDE + 1);

    // State memory holds the single state word.
    localparam int STATE_DEPTH = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCAN = 2'd0,
        CMD_DOWN = 2'd1,
        CMD_UP   = 2'd2,
        CMD_LOAD = 2'd3
    } t_cmd;

    // State word. The held cathode and sample are rebuilt downstream from
    // the count snapshot and the phase taken at the last scan tick.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SCAN_W-1:0]  scan_pos;
        logic [ANODE_W-1:0] anode;
        logic [COUNT_W-1:0] snap;
        logic [PHASE_W-1:0] phase;
    } t_state;

    localparam int STATE_W = $bits(t_state);

    typedef logic [ROM_W-1:0] t_rom [TABLE_SIZE];

    // Table entries floor(A*sin(i*turn/size)+A), evaluated at elaboration.
    function automatic t_rom build_sine_rom();
        t_rom rom;
        real  x;
        real  v;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            x = real'(i) * SINE_STEP;
            v = $floor(real'(SINE_AMPLITUDE) * $sin(x) + real'(SINE_AMPLITUDE));
            rom[i] = ROM_W'($rtoi(v));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_sine_rom();

endpackage

/* rtl/encoder_counter_digit_scan_sine_core.sv */
// ----------------------------------------------------------------------------
// encoder_counter_digit_scan_sine_core
// Rotation counter with a three-digit multiplexed display scan and a sine
// table sample generator.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       sink       i_in_valid / o_in_stall   i_cmd, i_load_value
//  out      source     o_out_valid / i_out_stall o_count_now, o_anode_select,
//                                                o_cathode_code, o_dac_level
//  cfg      sink       i_cfg_we                  i_cfg_wdata (count_top)
//
// One item per cycle sustained while the output is not stalled; each item's result
// passes the input register, digit stage and output register in that order,
// with the state update done ahead of the digit stage.
// The rate is set by the read-modify-write of the state word, with the
// written word forwarded past the registered memory read.
// Synchronous active-low reset clears all control state; no clearing pass.
// A stalled output holds its item and stalls each stage behind it in turn.
// ----------------------------------------------------------------------------
module encoder_counter_digit_scan_sine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ecdss_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ecdss_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ecdss_pkg::COUNT_W-1:0] i_load_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ecdss_pkg::COUNT_W-1:0] o_count_now,
    output logic [ecdss_pkg::ANODE_W-1:0] o_anode_select,
    output logic [ecdss_pkg::CATH_W-1:0]  o_cathode_code,
    output logic [ecdss_pkg::DAC_W-1:0]   o_dac_level
);
    import ecdss_pkg::*;

    logic   x_valid;
    logic   x_ready;
    t_state x_item;

    // Counter state update.
    ecdss_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_load_value (i_load_value),
        .o_x_valid    (x_valid),
        .o_x_item     (x_item),
        .i_x_ready    (x_ready)
    );

    // Display and sample pipeline.
    ecdss_disp u_disp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_x_valid      (x_valid),
        .i_x_item       (x_item),
        .o_x_ready      (x_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_count_now    (o_count_now),
        .o_anode_select (o_anode_select),
        .o_cathode_code (o_cathode_code),
        .o_dac_level    (o_dac_level)
    );

endmodule

/* rtl/ecdss_ram.sv */
// ----------------------------------------------------------------------------
// ecdss_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ecdss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read with the old contents on a same-cycle collision.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ecdss_state.sv */
// ----------------------------------------------------------------------------
// ecdss_state
// Input stage and read-modify-write of the state word in the state memory.
// ----------------------------------------------------------------------------
module ecdss_state (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ecdss_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ecdss_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ecdss_pkg::COUNT_W-1:0] i_load_value,
    output logic                         o_x_valid,
    output ecdss_pkg::t_state            o_x_item,
    input  logic                         i_x_ready
);
    import ecdss_pkg::*;

    localparam int ADDR_W = STATE_DEPTH > 1 ? $clog2(STATE_DEPTH) : 1;

    logic [COUNT_W-1:0] r_top;
    logic               r_x_v;
    t_cmd               r_x_cmd;
    logic [COUNT_W-1:0] r_x_load;
    logic               r_fwd_v;
    t_state             r_fwd;
    logic               r_init;

    logic               x_en;
    logic               adv;
    logic [COUNT_W-1:0] top;
    logic [STATE_W-1:0] ram_rd;
    t_state             cur;
    t_state             n_state;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= COUNT_LIMIT;
        end else if (i_cfg_we) begin
            r_top <= i_cfg_wdata;
        end
    end

    // Item register in front of the update.
    assign x_en       = !r_x_v || i_x_ready;
    assign o_in_stall = !x_en;
    assign adv        = r_x_v && i_x_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else if (x_en) begin
            r_x_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_en && i_in_valid) begin
            r_x_cmd  <= t_cmd'(i_cmd);
            r_x_load <= i_load_value;
        end
    end

    // State memory, read every cycle at the single entry.
    ecdss_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (adv),
        .i_waddr (ADDR_W'(0)),
        .i_wdata (n_state),
        .i_raddr (ADDR_W'(0)),
        .o_rdata (ram_rd)
    );

    // The read issued in the cycle of a write returns old data, so the
    // written word is forwarded in its place. Before the first write the
    // entry reads as the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
            r_init  <= 1'b0;
        end else begin
            r_fwd_v <= adv;
            if (adv) begin
                r_init <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd <= n_state;
        end
    end

    always_comb begin
        if (r_fwd_v) begin
            cur = r_fwd;
        end else if (r_init) begin
            cur = t_state'(ram_rd);
        end else begin
            cur = '0;
        end
    end

    // Effective top never exceeds three digits.
    assign top = (r_top > COUNT_LIMIT) ? COUNT_LIMIT : r_top;

    // Update of the state word for one item.
    always_comb begin
        n_state = cur;
        case (r_x_cmd)
            CMD_SCAN: begin
                n_state.anode    = ANODE_W'(1) << cur.scan_pos;
                n_state.snap     = cur.count;
                n_state.scan_pos = (cur.scan_pos >= SCAN_W'(LAST_DIGIT)) ?
                                   '0 : cur.scan_pos + SCAN_W'(1);
                n_state.phase    = (cur.phase == PHASE_W'(TABLE_SIZE - 1)) ?
                                   '0 : cur.phase + PHASE_W'(1);
            end
            CMD_DOWN: begin
                n_state.count = (cur.count == '0) ? top : cur.count - COUNT_W'(1);
            end
            CMD_UP: begin
                n_state.count = (cur.count >= top) ? '0 : cur.count + COUNT_W'(1);
            end
            CMD_LOAD: begin
                n_state.count = (r_x_load > top) ? top : r_x_load;
            end
            default: begin
                n_state = cur;
            end
        endcase
    end

    assign o_x_valid = r_x_v;
    assign o_x_item  = n_state;

endmodule

/* rtl/ecdss_disp.sv */
// ----------------------------------------------------------------------------
// ecdss_disp
// Display pipeline: digit extraction, sine table read and output register.
// ----------------------------------------------------------------------------
module ecdss_disp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_x_valid,
    input  ecdss_pkg::t_state            i_x_item,
    output logic                         o_x_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ecdss_pkg::COUNT_W-1:0] o_count_now,
    output logic [ecdss_pkg::ANODE_W-1:0] o_anode_select,
    output logic [ecdss_pkg::CATH_W-1:0]  o_cathode_code,
    output logic [ecdss_pkg::DAC_W-1:0]   o_dac_level
);
    import ecdss_pkg::*;

    logic               r_p1_v;
    logic [COUNT_W-1:0] r_p1_count;
    logic [ANODE_W-1:0] r_p1_anode;
    logic [COUNT_W-1:0] r_p1_dig;
    logic [DAC_W-1:0]   r_p1_dac;

    logic               r_out_v;
    logic [COUNT_W-1:0] r_out_count;
    logic [ANODE_W-1:0] r_out_anode;
    logic [CATH_W-1:0]  r_out_cath;
    logic [DAC_W-1:0]   r_out_dac;

    logic               p1_en;
    logic               p2_en;
    logic [PROD_W-1:0]  prod_tens;
    logic [PROD_W-1:0]  prod_hund;
    logic [COUNT_W-1:0] sel_dig;
    logic [DAC_W-1:0]   sel_dac;
    logic [PROD_W-1:0]  prod_mod;
    logic [COUNT_W-1:0] quot;
    logic [CATH_W-1:0]  cath;

    assign p2_en     = !r_out_v || !i_out_stall;
    assign p1_en     = !r_p1_v || p2_en;
    assign o_x_ready = p1_en;

    // Shift the shown digit down to the units place; the sample is zero
    // until the first scan tick.
    assign prod_tens = PROD_W'(i_x_item.snap) * PROD_W'(DIV10_MUL);
    assign prod_hund = PROD_W'(i_x_item.snap) * PROD_W'(DIV100_MUL);

    always_comb begin
        if (i_x_item.anode[2]) begin
            sel_dig = COUNT_W'(prod_hund >> DIV100_SHIFT);
        end else if (i_x_item.anode[1]) begin
            sel_dig = COUNT_W'(prod_tens >> DIV10_SHIFT);
        end else begin
            sel_dig = i_x_item.snap;
        end
    end

    assign sel_dac = (i_x_item.anode != '0) ? DAC_W'(SINE_ROM[i_x_item.phase]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (p1_en) begin
            r_p1_v <= i_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_en && i_x_valid) begin
            r_p1_count <= i_x_item.count;
            r_p1_anode <= i_x_item.anode;
            r_p1_dig   <= sel_dig;
            r_p1_dac   <= sel_dac;
        end
    end

    // Units digit of the shifted value.
    assign prod_mod = PROD_W'(r_p1_dig) * PROD_W'(DIV10_MUL);
    assign quot     = COUNT_W'(prod_mod >> DIV10_SHIFT);
    assign cath     = CATH_W'(r_p1_dig - COUNT_W'(quot * COUNT_W'(DIGIT_BASE)));

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (p2_en) begin
            r_out_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p2_en && r_p1_v) begin
            r_out_count <= r_p1_count;
            r_out_anode <= r_p1_anode;
            r_out_cath  <= cath;
            r_out_dac   <= r_p1_dac;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_count_now    = r_out_count;
    assign o_anode_select = r_out_anode;
    assign o_cathode_code = r_out_cath;
    assign o_dac_level    = r_out_dac;

endmodule

/* rtl/ecdss_checker.sv */
// ----------------------------------------------------------------------------
// ecdss_checker
// Port-level checks of the rotation counter core, bound to the top level.
// ----------------------------------------------------------------------------
module ecdss_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_we,
    input logic [ecdss_pkg::COUNT_W-1:0] i_cfg_wdata,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [ecdss_pkg::CMD_W-1:0]   i_cmd,
    input logic [ecdss_pkg::COUNT_W-1:0] i_load_value,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [ecdss_pkg::COUNT_W-1:0] o_count_now,
    input logic [ecdss_pkg::ANODE_W-1:0] o_anode_select,
    input logic [ecdss_pkg::CATH_W-1:0]  o_cathode_code,
    input logic [ecdss_pkg::DAC_W-1:0]   o_dac_level
);
    import ecdss_pkg::*;

    // The count never leaves the three-digit range.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count_now <= COUNT_LIMIT)
        else $error("count above the three-digit limit");

    // At most one anode is lit.
    a_anode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_anode_select))
        else $error("more than one anode lit");

    // The cathode code is a decimal digit.
    a_cathode_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cathode_code < CATH_W'(DIGIT_BASE))
        else $error("cathode code is not a decimal digit");

    // Before the first scan tick the digit and the sample are both zero.
    a_idle_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_anode_select == '0) |->
        (o_cathode_code == '0 && o_dac_level == '0))
        else $error("display output before the first scan tick");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_count_now) && $stable(o_anode_select) &&
         $stable(o_cathode_code) && $stable(o_dac_level)))
        else $error("stalled result item changed");

endmodule

bind encoder_counter_digit_scan_sine_core ecdss_checker u_ecdss_checker (.*);
